@@ src/nta_pkg.sv @@
`default_nettype none
package nta_pkg;

  typedef struct packed {
    logic        kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  detection_index;
    logic [15:0] track_id;
    logic        is_new;
    logic        marked_deleted;
    logic        table_full;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [11:0] search_radius;
    logic [15:0] extinction_age;
    logic [7:0]  expansion_step;
    logic [7:0]  min_closeness;
  } cfg_t;

  localparam logic [1:0] CFG_SEARCH_RADIUS  = 2'd0;
  localparam logic [1:0] CFG_EXTINCTION_AGE = 2'd1;
  localparam logic [1:0] CFG_EXPANSION_STEP = 2'd2;
  localparam logic [1:0] CFG_MIN_CLOSENESS  = 2'd3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_EMPTY_FRAME, OP_DRD, OP_DCAP,
    OP_TRD, OP_TCAP, OP_TSQ, OP_TSUM, OP_JRD, OP_JCAP, OP_JSQ, OP_JSUM,
    OP_TNEXT, OP_MATCH, OP_MCHK, OP_FRD, OP_FCAP, OP_START_FRAME
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic t_last;
    logic det_empty;
    logic det_last;
    logic cand;
    logic j_is_i;
    logic j_last;
    logic e_lt_d;
    logic matched;
    logic free_here;
  } status_t;

endpackage
`default_nettype wire

@@ src/nta_cfg.sv @@
`default_nettype none
module nta_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output nta_pkg::cfg_t    cfg
);
  import nta_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.search_radius  <= 12'd200;
      cfg_r.extinction_age <= 16'd75;
      cfg_r.expansion_step <= 8'd20;
      cfg_r.min_closeness  <= 8'd15;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SEARCH_RADIUS:  cfg_r.search_radius  <= cfg_data[11:0];
        CFG_EXTINCTION_AGE: cfg_r.extinction_age <= cfg_data;
        CFG_EXPANSION_STEP: cfg_r.expansion_step <= cfg_data[7:0];
        CFG_MIN_CLOSENESS:  cfg_r.min_closeness  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ src/nta_ctrl.sv @@
`default_nettype none
module nta_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       kind,
  output logic            busy,
  input  wire nta_pkg::status_t sts,
  output nta_pkg::cmd_t   cmd
);
  import nta_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DRD, S_DCAP, S_TRD, S_TCAP, S_TSQ, S_TSUM,
    S_JRD, S_JCAP, S_JSQ, S_JSUM, S_TNEXT, S_MATCH, S_MCHK, S_FRD, S_FCAP
  } state_t;

  state_t state_r, state_nxt;
  state_t done_st;

  assign busy    = (state_r != S_IDLE);
  assign done_st = sts.det_last ? S_IDLE : S_DRD;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.t_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_LOAD) begin
            cmd.op = OP_LOAD;
          end else if (sts.det_empty) begin
            cmd.op = OP_EMPTY_FRAME;
          end else begin
            cmd.op    = OP_START_FRAME;
            state_nxt = S_DRD;
          end
        end
      end
      S_DRD: begin
        cmd.op = OP_DRD; state_nxt = S_DCAP;
      end
      S_DCAP: begin
        cmd.op = OP_DCAP; state_nxt = S_TRD;
      end
      S_TRD: begin
        cmd.op = OP_TRD; state_nxt = S_TCAP;
      end
      S_TCAP: begin
        cmd.op = OP_TCAP; state_nxt = S_TSQ;
      end
      S_TSQ: begin
        cmd.op = OP_TSQ; state_nxt = S_TSUM;
      end
      S_TSUM: begin
        cmd.op    = OP_TSUM;
        state_nxt = sts.cand ? S_JRD : S_TNEXT;
      end
      S_JRD: begin
        cmd.op = OP_JRD;
        if (!sts.j_is_i)     state_nxt = S_JCAP;
        else if (sts.j_last) state_nxt = S_TNEXT;
      end
      S_JCAP: begin
        cmd.op = OP_JCAP; state_nxt = S_JSQ;
      end
      S_JSQ: begin
        cmd.op = OP_JSQ; state_nxt = S_JSUM;
      end
      S_JSUM: begin
        cmd.op    = OP_JSUM;
        state_nxt = (sts.e_lt_d || sts.j_last) ? S_TNEXT : S_JRD;
      end
      S_TNEXT: begin
        cmd.op    = OP_TNEXT;
        state_nxt = sts.t_last ? S_MATCH : S_TRD;
      end
      S_MATCH: begin
        cmd.op = OP_MATCH; state_nxt = S_MCHK;
      end
      S_MCHK: begin
        cmd.op    = OP_MCHK;
        state_nxt = sts.matched ? done_st : S_FRD;
      end
      S_FRD: begin
        cmd.op = OP_FRD; state_nxt = S_FCAP;
      end
      S_FCAP: begin
        cmd.op    = OP_FCAP;
        state_nxt = (sts.free_here || sts.t_last) ? done_st : S_FRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

@@ src/nta_dp.sv @@
`default_nettype none
module nta_dp #(
  parameter int DETECTIONS = 32,
  parameter int TRACKS     = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire nta_pkg::cmd_t     cmd,
  input  wire nta_pkg::in_item_t in_item,
  input  wire nta_pkg::cfg_t     cfg,
  output nta_pkg::status_t  sts,
  output logic              out_valid,
  output nta_pkg::out_item_t out_item
);
  import nta_pkg::*;

  localparam int DW  = $clog2(DETECTIONS);
  localparam int DCW = $clog2(DETECTIONS + 1);
  localparam int TW  = $clog2(TRACKS);

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } det_rec_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] frame;
    logic [15:0] id;
    logic        valid;
    logic        deleted;
  } trk_rec_t;

  function automatic logic [15:0] absdiff(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  det_rec_t det_mem [DETECTIONS];
  trk_rec_t trk_mem [TRACKS];
  det_rec_t det_q;
  trk_rec_t trk_q;

  logic [DCW-1:0] cnt_r;
  logic [DW-1:0]  i_r, j_r;
  logic [TW-1:0]  t_r, best_t_r;
  logic [15:0]    px_r, py_r, tx_r, ty_r, tid_r, best_id_r, nid_r;
  logic [31:0]    tfr_r, fc_r, best_age_r, sqx_r, sqy_r, r2_r;
  logic [23:0]    mc2_r;
  logic [15:0]    dx_r, dy_r, s_r;
  logic [32:0]    d_r, best_d_r, sum;
  logic           alive_r, cand_r, better_r, close_r, found_r, best_del_r, big_r;
  logic           out_valid_r;
  out_item_t      out_r;

  logic           q_alive, t_last, det_last, emit;
  logic [32:0]    age1;
  logic [20:0]    prod;
  logic           trk_we;
  logic [TW-1:0]  trk_wa;
  trk_rec_t       trk_wd;
  out_item_t      res;
  logic [6:0]     i_ext;

  assign sum      = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign q_alive  = trk_q.valid && !trk_q.deleted &&
                    ((fc_r - trk_q.frame) < {16'd0, cfg.extinction_age});
  assign t_last   = (t_r == TW'(TRACKS - 1));
  assign det_last = (i_r == DW'(cnt_r - 1'b1));
  assign age1     = {1'b0, best_age_r} + 33'd1;
  assign prod     = 21'(age1[12:0]) * 21'(cfg.expansion_step);
  assign i_ext    = 7'(i_r);

  assign sts.t_last    = t_last;
  assign sts.det_empty = (cnt_r == '0);
  assign sts.det_last  = det_last;
  assign sts.cand      = alive_r && (sum < {1'b0, r2_r});
  assign sts.j_is_i    = (j_r == i_r);
  assign sts.j_last    = (j_r == DW'(cnt_r - 1'b1));
  assign sts.e_lt_d    = (sum < d_r);
  assign sts.matched   = found_r &&
                         (big_r || ({1'b0, 32'(s_r) * 32'(s_r)} > best_d_r));
  assign sts.free_here = !q_alive;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // track writes and result building
  always_comb begin
    trk_we = 1'b0;
    trk_wa = t_r;
    trk_wd = '{x: px_r, y: py_r, frame: fc_r, id: nid_r, valid: 1'b1, deleted: 1'b0};
    emit   = 1'b0;
    res    = '{detection_index: i_ext[4:0], track_id: 16'd0, is_new: 1'b0,
               marked_deleted: 1'b0, table_full: 1'b0, last: det_last};
    case (cmd.op)
      OP_CLEAR: begin
        trk_we       = 1'b1;
        trk_wd.valid = 1'b0;
      end
      OP_MCHK: begin
        if (sts.matched) begin
          trk_we             = 1'b1;
          trk_wa             = best_t_r;
          trk_wd.id          = best_id_r;
          trk_wd.deleted     = best_del_r;
          emit               = 1'b1;
          res.track_id       = best_id_r;
          res.marked_deleted = best_del_r;
        end
      end
      OP_FCAP: begin
        if (!q_alive) begin
          trk_we       = 1'b1;
          emit         = 1'b1;
          res.track_id = nid_r;
          res.is_new   = 1'b1;
        end else if (t_last) begin
          emit           = 1'b1;
          res.table_full = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && cnt_r < DCW'(DETECTIONS))
      det_mem[cnt_r[DW-1:0]] <= '{x: in_item.pos_x, y: in_item.pos_y};
    det_q <= det_mem[(cmd.op == OP_JRD) ? j_r : i_r];
    if (trk_we) trk_mem[trk_wa] <= trk_wd;
    trk_q <= trk_mem[t_r];
  end

  // payload
  always_ff @(posedge clk) begin
    r2_r  <= 32'({cfg.search_radius, 4'd0}) * 32'({cfg.search_radius, 4'd0});
    mc2_r <= 24'({cfg.min_closeness, 4'd0}) * 24'({cfg.min_closeness, 4'd0});
    out_r <= res;
    case (cmd.op)
      OP_DCAP: begin
        px_r    <= det_q.x;
        py_r    <= det_q.y;
        found_r <= 1'b0;
      end
      OP_TCAP: begin
        tx_r    <= trk_q.x;
        ty_r    <= trk_q.y;
        tid_r   <= trk_q.id;
        tfr_r   <= trk_q.frame;
        alive_r <= q_alive;
        dx_r    <= absdiff(px_r, trk_q.x);
        dy_r    <= absdiff(py_r, trk_q.y);
      end
      OP_TSQ, OP_JSQ: begin
        sqx_r <= 32'(dx_r) * 32'(dx_r);
        sqy_r <= 32'(dy_r) * 32'(dy_r);
      end
      OP_TSUM: begin
        d_r      <= sum;
        cand_r   <= sts.cand;
        better_r <= 1'b0;
        close_r  <= 1'b0;
      end
      OP_JCAP: begin
        dx_r <= absdiff(det_q.x, tx_r);
        dy_r <= absdiff(det_q.y, ty_r);
      end
      OP_JSUM: begin
        if (sts.e_lt_d)                       better_r <= 1'b1;
        else if (sum < {9'd0, mc2_r})         close_r  <= 1'b1;
      end
      OP_TNEXT: begin
        if (cand_r && !better_r && (!found_r || d_r < best_d_r)) begin
          found_r    <= 1'b1;
          best_t_r   <= t_r;
          best_d_r   <= d_r;
          best_age_r <= fc_r - tfr_r;
          best_del_r <= close_r;
          best_id_r  <= tid_r;
        end
      end
      OP_MATCH: begin
        // past 4095 pixels the radius exceeds any candidate distance
        big_r <= ((age1 >= 33'd4096) && (cfg.expansion_step != 8'd0)) ||
                 (prod >= 21'd4096);
        s_r   <= {prod[11:0], 4'd0};
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      t_r         <= '0;
      fc_r        <= '0;
      nid_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
      case (cmd.op)
        OP_CLEAR:       t_r <= t_last ? '0 : t_r + 1'b1;
        OP_LOAD:        if (cnt_r < DCW'(DETECTIONS)) cnt_r <= cnt_r + 1'b1;
        OP_EMPTY_FRAME: fc_r <= fc_r + 32'd1;
        OP_START_FRAME: i_r <= '0;
        OP_DCAP:        t_r <= '0;
        OP_TSUM:        j_r <= '0;
        OP_JRD:         if (sts.j_is_i) j_r <= j_r + 1'b1;
        OP_JSUM:        j_r <= j_r + 1'b1;
        OP_TNEXT:       t_r <= t_last ? '0 : t_r + 1'b1;
        OP_FCAP: begin
          if (!q_alive)    nid_r <= nid_r + 16'd1;
          else if (!t_last) t_r <= t_r + 1'b1;
        end
        default: ;
      endcase
      if (emit) begin
        if (det_last) begin
          cnt_r <= '0;
          fc_r  <= fc_r + 32'd1;
        end else begin
          i_r <= i_r + 1'b1;
        end
        if (cmd.op == OP_MCHK || cmd.op == OP_FCAP) t_r <= '0;
      end
    end
  end
endmodule
`default_nettype wire

@@ src/nearest_track_association.sv @@
// channel  ports                         transfer when
// -------  ----------------------------  --------------------------------
// input    start, busy, in_item          start high and busy low
// result   out_valid, out_item           out_valid high, one cycle each
// config   cfg_valid, cfg_ready,         cfg_valid and cfg_ready high
//          cfg_index, cfg_data           (cfg_ready is always high)
//
// a load is stored without raising busy; end of frame runs a track walk
// per detection, with an inner walk over the detection memory
// after reset a clearing pass writes every track slot, with busy high
// results are strobed one per detection and cannot be held off
`default_nettype none
module nearest_track_association #(
  parameter int DETECTIONS = 32,
  parameter int TRACKS     = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire nta_pkg::in_item_t in_item,
  output logic               out_valid,
  output nta_pkg::out_item_t out_item,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);
  import nta_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t sts;

  // configuration registers
  nta_cfg u_cfg (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
  );

  // sequencer
  nta_ctrl u_ctrl (
    .clk, .rst_n, .start, .kind(in_item.kind), .busy, .sts, .cmd
  );

  // memories, distance unit and result register
  nta_dp #(.DETECTIONS(DETECTIONS), .TRACKS(TRACKS)) u_dp (
    .clk, .rst_n, .cmd, .in_item, .cfg, .sts, .out_valid, .out_item
  );
endmodule
`default_nettype wire
